@@ hdl/at_rwm_pkg.sv @@
package at_rwm_pkg;

  // Item function codes
  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_BYTE  = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;
  localparam logic [1:0] FUNC_READ  = 2'd3;

  // End reason codes
  localparam logic [2:0] REASON_NONE    = 3'd0;
  localparam logic [2:0] REASON_EXPECT  = 3'd1;
  localparam logic [2:0] REASON_ERROR   = 3'd2;
  localparam logic [2:0] REASON_FULL    = 3'd3;
  localparam logic [2:0] REASON_TIMEOUT = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] CFG_EXPECT_LOW  = 3'd0;
  localparam logic [2:0] CFG_EXPECT_HIGH = 3'd1;
  localparam logic [2:0] CFG_EXPECT_LEN  = 3'd2;
  localparam logic [2:0] CFG_ERROR_TEXT  = 3'd3;
  localparam logic [2:0] CFG_ERROR_LEN   = 3'd4;
  localparam logic [2:0] CFG_TIMEOUT     = 3'd5;

  localparam int          IDLE_W            = 24;
  localparam logic [63:0] ERROR_TEXT_RESET  = 64'd353518113349;
  localparam logic [3:0]  ERROR_LEN_RESET   = 4'd5;
  localparam logic [23:0] TIMEOUT_RESET     = 24'd500000;

  // Pattern setup shared by every window cell (lengths already clamped)
  typedef struct packed {
    logic [127:0] expect_bytes;
    logic [4:0]   expect_len;
    logic [63:0]  error_bytes;
    logic [3:0]   error_len;
  } pattern_t;

  // Per-cell compare result against the incoming byte
  typedef struct packed {
    logic exp_ok;
    logic err_ok;
  } cell_match_t;

endpackage

@@ hdl/at_rwm_cell.sv @@
module at_rwm_cell #(
  parameter int INDEX = 0
) (
  input  logic                   clk,
  input  logic                   shift_en,
  input  logic [7:0]             din,
  input  at_rwm_pkg::pattern_t   pattern,
  output logic [7:0]             dout,
  output at_rwm_pkg::cell_match_t match
);
  import at_rwm_pkg::*;

  logic [7:0] data;
  logic [3:0] exp_pos;
  logic [2:0] err_pos;
  logic       exp_use;
  logic       err_use;

  // Shift in the neighbor's byte; this cell holds the byte INDEX places back
  always_ff @(posedge clk) begin
    if (shift_en) begin
      data <= din;
    end
  end

  assign dout = data;

  // Pattern position lined up with this cell once din lands here
  assign exp_use = 5'(INDEX) < pattern.expect_len;
  assign err_use = 4'(INDEX) < pattern.error_len;
  assign exp_pos = 4'(pattern.expect_len - 5'(INDEX) - 5'd1);
  assign err_pos = 3'(pattern.error_len - 4'(INDEX) - 4'd1);

  always_comb begin
    match.exp_ok = !exp_use || (din == pattern.expect_bytes[exp_pos*8 +: 8]);
    match.err_ok = !err_use || (din == pattern.error_bytes[err_pos*8 +: 8]);
  end

endmodule

@@ hdl/at_rwm_capture.sv @@
module at_rwm_capture #(
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [7:0]               wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [7:0]               rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Hold read data until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hdl/at_reply_wait_matcher.sv @@
// Modem reply wait matcher. A start word arms the wait and empties the capture;
// each received byte word is appended to the capture and shifted into a row of
// window cells, each comparing its incoming byte against the expected and the
// error pattern, so the suffix test finishes in the cycle the byte is taken.
// The expected pattern wins over the error pattern; a held zero byte blocks
// both; CAPTURE_BYTES-1 held bytes end the wait as buffer full. Tick words
// count idle time up to timeout_limit. Read words return a captured byte.
// Every input word yields exactly one result word, registered in the cycle after
// acceptance. A new word is taken every cycle unless a finished result is
// still stalled at the output. Bytes never captured in the current wait read
// back as zero; no clearing pass runs after reset. Write configuration only
// while no word is in flight.
module at_reply_wait_matcher #(
  parameter int CAPTURE_BYTES = 64,
  parameter int EXPECT_MAX    = 16,
  parameter int ERROR_MAX     = 8
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [7:0]  rx_byte,
  input  logic [5:0]  read_index,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        done_res,
  output logic        success,
  output logic [2:0]  end_reason,
  output logic [5:0]  byte_count,
  output logic [7:0]  read_data,
  output logic        read_valid
);
  import at_rwm_pkg::*;

  localparam int CW     = $clog2(CAPTURE_BYTES);
  localparam int CMPW   = (CW + 1 > 6) ? CW + 1 : 6;
  localparam int WD     = (EXPECT_MAX > ERROR_MAX) ? EXPECT_MAX : ERROR_MAX;
  localparam logic [IDLE_W-1:0] IDLE_MAX = {IDLE_W{1'b1}};
  localparam logic [CMPW-1:0]   FULL_AT  = CMPW'(CAPTURE_BYTES - 1);

  // configuration registers
  logic [63:0]       expect_low_bytes;
  logic [63:0]       expect_high_bytes;
  logic [4:0]        expect_length;
  logic [63:0]       error_text;
  logic [3:0]        error_length;
  logic [IDLE_W-1:0] timeout_limit;

  // wait state
  logic [CW-1:0]     count;
  logic [IDLE_W-1:0] idle;
  logic              waiting;
  logic              zero_seen;
  logic              last_success;
  logic [2:0]        last_reason;

  logic [CW-1:0]     count_next;
  logic [IDLE_W-1:0] idle_next;
  logic              waiting_next;
  logic              zero_seen_next;
  logic              last_success_next;
  logic [2:0]        last_reason_next;
  logic              done_next;

  logic              accept;
  logic              is_byte;
  logic              is_tick;
  logic              is_read;
  logic              read_hit;
  logic              read_hit_q;
  logic              read_valid_q;
  logic [7:0]        mem_data;

  logic [CMPW-1:0]   count_inc;
  logic [CMPW-1:0]   idx_x;
  logic [IDLE_W-1:0] idle_inc;
  logic              zero_now;
  logic              exp_hit;
  logic              err_hit;
  logic              full_hit;

  pattern_t          pattern;
  logic [7:0]        chain [WD+1];
  cell_match_t       match [WD];
  logic [WD-1:0]     exp_ok_vec;
  logic [WD-1:0]     err_ok_vec;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign is_byte  = accept && (func == FUNC_BYTE) && waiting;
  assign is_tick  = accept && (func == FUNC_TICK) && waiting;
  assign is_read  = accept && (func == FUNC_READ);

  // Configuration writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      expect_low_bytes  <= '0;
      expect_high_bytes <= '0;
      expect_length     <= '0;
      error_text        <= ERROR_TEXT_RESET;
      error_length      <= ERROR_LEN_RESET;
      timeout_limit     <= TIMEOUT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_EXPECT_LOW:  expect_low_bytes  <= cfg_data;
        CFG_EXPECT_HIGH: expect_high_bytes <= cfg_data;
        CFG_EXPECT_LEN:  expect_length     <= cfg_data[4:0];
        CFG_ERROR_TEXT:  error_text        <= cfg_data;
        CFG_ERROR_LEN:   error_length      <= cfg_data[3:0];
        CFG_TIMEOUT:     timeout_limit     <= cfg_data[IDLE_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp pattern lengths to what the window can check
  always_comb begin
    pattern.expect_bytes = {expect_high_bytes, expect_low_bytes};
    pattern.error_bytes  = error_text;
    pattern.expect_len   = (expect_length > 5'(EXPECT_MAX)) ? 5'(EXPECT_MAX) : expect_length;
    pattern.error_len    = (error_length > 4'(ERROR_MAX)) ? 4'(ERROR_MAX) : error_length;
  end

  // Window: cell 0 takes the new byte, each later cell its neighbor's byte
  assign chain[0] = rx_byte;

  for (genvar g = 0; g < WD; g++) begin : g_cell
    at_rwm_cell #(
      .INDEX (g)
    ) u_cell (
      .clk      (clk),
      .shift_en (is_byte),
      .din      (chain[g]),
      .pattern  (pattern),
      .dout     (chain[g+1]),
      .match    (match[g])
    );
    assign exp_ok_vec[g] = match[g].exp_ok;
    assign err_ok_vec[g] = match[g].err_ok;
  end

  // Suffix tests on the capture as it stands after this byte
  assign count_inc = CMPW'(count) + CMPW'(1);
  assign zero_now  = zero_seen || (rx_byte == 8'd0);
  assign exp_hit   = !zero_now && (pattern.expect_len != 5'd0) &&
                     (count_inc >= CMPW'(pattern.expect_len)) && (&exp_ok_vec);
  assign err_hit   = !zero_now && (pattern.error_len != 4'd0) &&
                     (count_inc >= CMPW'(pattern.error_len)) && (&err_ok_vec);
  assign full_hit  = count_inc >= FULL_AT;
  assign idle_inc  = (idle == IDLE_MAX) ? idle : idle + IDLE_W'(1);

  always_comb begin
    count_next        = count;
    idle_next         = idle;
    waiting_next      = waiting;
    zero_seen_next    = zero_seen;
    last_success_next = last_success;
    last_reason_next  = last_reason;
    done_next         = 1'b0;
    if (accept && (func == FUNC_START)) begin
      count_next        = '0;
      idle_next         = '0;
      zero_seen_next    = 1'b0;
      last_success_next = 1'b0;
      last_reason_next  = REASON_NONE;
      waiting_next      = 1'b1;
    end else if (is_byte) begin
      count_next     = count_inc[CW-1:0];
      idle_next      = '0;
      zero_seen_next = zero_now;
      priority if (exp_hit) begin
        waiting_next      = 1'b0;
        last_success_next = 1'b1;
        last_reason_next  = REASON_EXPECT;
        done_next         = 1'b1;
      end else if (err_hit) begin
        waiting_next      = 1'b0;
        last_success_next = 1'b0;
        last_reason_next  = REASON_ERROR;
        done_next         = 1'b1;
      end else if (full_hit) begin
        waiting_next      = 1'b0;
        last_success_next = 1'b0;
        last_reason_next  = REASON_FULL;
        done_next         = 1'b1;
      end else begin
        waiting_next = 1'b1;
      end
    end else if (is_tick) begin
      idle_next = idle_inc;
      if (idle_inc >= timeout_limit) begin
        waiting_next      = 1'b0;
        last_success_next = 1'b0;
        last_reason_next  = REASON_TIMEOUT;
        done_next         = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      idle         <= '0;
      waiting      <= 1'b0;
      zero_seen    <= 1'b0;
      last_success <= 1'b0;
      last_reason  <= REASON_NONE;
    end else begin
      count        <= count_next;
      idle         <= idle_next;
      waiting      <= waiting_next;
      zero_seen    <= zero_seen_next;
      last_success <= last_success_next;
      last_reason  <= last_reason_next;
    end
  end

  // Capture store; only bytes below the count are live in this wait
  assign idx_x    = CMPW'(read_index);
  assign read_hit = idx_x < CMPW'(count);

  at_rwm_capture #(
    .DEPTH (CAPTURE_BYTES)
  ) u_capture (
    .clk     (clk),
    .wr_en   (is_byte),
    .wr_addr (count),
    .wr_data (rx_byte),
    .rd_en   (is_read),
    .rd_addr (idx_x[CW-1:0]),
    .rd_data (mem_data)
  );

  // Result register: load on accept, hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      done_res     <= done_next;
      success      <= last_success_next;
      end_reason   <= last_reason_next;
      byte_count   <= 6'(count_next);
      read_hit_q   <= is_read && read_hit;
      read_valid_q <= is_read && read_hit && last_success;
    end
  end

  assign read_data  = read_hit_q ? mem_data : 8'd0;
  assign read_valid = read_valid_q;

endmodule
